### src/ppnd_pkg.sv
package ppnd_pkg;

  localparam int unsigned SIDES_DEF  = 6;
  localparam int unsigned RING_DEPTH = 4;
  localparam int unsigned PIN_W      = 6;
  localparam int unsigned NPOS       = 6;
  localparam int unsigned VAL_W      = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned STEP_W     = $clog2(RING_DEPTH);

  localparam logic [7:0] STALE_RST = 8'd100;
  localparam logic [2:0] SHIFT_RST = 3'd3;
  localparam logic [7:0] RAPID_RST = 8'd10;

  localparam logic [VAL_W-1:0] VALUE_MAX = 4'd15;
  localparam logic [7:0]       RAPID_SAT = 8'd255;
  localparam logic [7:0]       CLICK_CNT = 8'd2;

  // Output position of each side; sides six and seven are never reported.
  localparam logic [2:0] POS_OF [8] = '{3'd0, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3, 3'd6, 3'd7};

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PIN   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_STALE = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_RAPID = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PIN,
    S_QRY
  } state_e;

  typedef struct packed {
    logic [7:0] stale_limit;
    logic [2:0] period_shift;
    logic [7:0] rapid_limit;
  } cfg_t;

  typedef struct packed {
    logic              pin_en;
    logic              qry_en;
    logic              qry_last;
    logic [STEP_W-1:0] step;
  } lane_cmd_t;

  typedef struct packed {
    opcode_e          opcode;
    logic [PIN_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [VAL_W-1:0] side_value_0;
    logic [VAL_W-1:0] side_value_1;
    logic [VAL_W-1:0] side_value_2;
    logic [VAL_W-1:0] side_value_3;
    logic [VAL_W-1:0] side_value_4;
    logic [VAL_W-1:0] side_value_5;
    logic [PIN_W-1:0] click_sides;
  } out_item_t;

endpackage

### src/ppnd_lane.sv
module ppnd_lane import ppnd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_cmd_t         cmd_i,
  input  logic              rise_i,
  input  logic [TIME_W-1:0] count_i,
  input  cfg_t              cfg_i,
  output logic              click_o,
  output logic [VAL_W-1:0]  value_o
);

  // Edge ring kept as a shift line: tap 0 is the newest edge time.
  logic [TIME_W-1:0] edge_q [RING_DEPTH];
  logic [TIME_W-1:0] edge_d [RING_DEPTH];
  logic [7:0]        rapid_q, rapid_d;
  logic [VAL_W-1:0]  rem_q, rem_d;
  logic              age_stale_q, age_stale_d;
  logic              per_stale_q, per_stale_d;
  logic [VAL_W-1:0]  qv_q [2];
  logic [VAL_W-1:0]  qv_d [2];

  logic [TIME_W-1:0] opa, opb, diff;
  logic              over_stale, is_rapid, any_per;
  logic [7:0]        shifted, rapid_inc;
  logic [VAL_W-1:0]  qv;

  // One shared subtractor, fed from the taps by the current step.
  always_comb begin
    case (cmd_i.step)
      2'd0: begin
        opa = count_i;
        opb = edge_q[0];
      end
      2'd1: begin
        opa = edge_q[0];
        opb = edge_q[1];
      end
      2'd2: begin
        opa = edge_q[1];
        opb = edge_q[2];
      end
      2'd3: begin
        opa = edge_q[2];
        opb = edge_q[3];
      end
      default: begin
        opa = count_i;
        opb = edge_q[0];
      end
    endcase
    diff       = opa - opb;
    over_stale = diff > {24'd0, cfg_i.stale_limit};
    is_rapid   = diff < {24'd0, cfg_i.rapid_limit};
    // A period that is not stale fits in eight bits.
    shifted    = diff[7:0] >> cfg_i.period_shift;
    qv         = (shifted > {4'd0, VALUE_MAX}) ? VALUE_MAX : shifted[VAL_W-1:0];
    rapid_inc  = (rapid_q == RAPID_SAT) ? RAPID_SAT : rapid_q + 8'd1;
    any_per    = per_stale_q | over_stale;
  end

  always_comb begin
    edge_d      = edge_q;
    rapid_d     = rapid_q;
    rem_d       = rem_q;
    age_stale_d = age_stale_q;
    per_stale_d = per_stale_q;
    qv_d        = qv_q;
    click_o     = 1'b0;
    value_o     = '0;

    if (cmd_i.pin_en && rise_i) begin
      if (is_rapid) begin
        rapid_d = rapid_inc;
        click_o = (rapid_inc == CLICK_CNT);
      end else begin
        rapid_d = '0;
        for (int k = RING_DEPTH - 1; k > 0; k--) begin
          edge_d[k] = edge_q[k-1];
        end
        edge_d[0] = count_i;
      end
    end

    if (cmd_i.qry_en) begin
      case (cmd_i.step)
        2'd0: begin
          age_stale_d = over_stale;
          per_stale_d = 1'b0;
        end
        2'd1: begin
          per_stale_d = over_stale;
          qv_d[0]     = qv;
        end
        2'd2: begin
          per_stale_d = any_per;
          qv_d[1]     = qv;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.qry_last) begin
      if (age_stale_q) begin
        value_o = '0;
      end else if (any_per) begin
        rem_d   = '0;
        value_o = '0;
      end else if (qv_q[0] == qv_q[1] && qv_q[0] == qv) begin
        rem_d   = qv;
        value_o = qv;
      end else begin
        value_o = rem_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        edge_q[k] <= '0;
      end
      rapid_q     <= '0;
      rem_q       <= '0;
      age_stale_q <= 1'b0;
      per_stale_q <= 1'b0;
    end else begin
      edge_q      <= edge_d;
      rapid_q     <= rapid_d;
      rem_q       <= rem_d;
      age_stale_q <= age_stale_d;
      per_stale_q <= per_stale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qv_q <= qv_d;
  end

endmodule

### src/ppnd_merge.sv
module ppnd_merge import ppnd_pkg::*; #(
  parameter int unsigned SIDES = SIDES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        kind_i,
  input  logic [SIDES-1:0]            clicks_i,
  input  logic [SIDES-1:0][VAL_W-1:0] values_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output out_item_t                   out_req_o
);

  logic              valid_q, valid_d;
  out_item_t         res_q;
  out_item_t         res_d;
  logic [VAL_W-1:0]  shown [8];
  logic [PIN_W-1:0]  clk_bits;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      shown[p] = '0;
    end
    clk_bits = '0;
    for (int i = 0; i < SIDES; i++) begin
      shown[POS_OF[i]] = values_i[i];
      if (i < PIN_W) begin
        clk_bits[i] = clicks_i[i];
      end
    end

    res_d.result_kind = kind_i;
    if (kind_i) begin
      res_d.side_value_0 = '0;
      res_d.side_value_1 = '0;
      res_d.side_value_2 = '0;
      res_d.side_value_3 = '0;
      res_d.side_value_4 = '0;
      res_d.side_value_5 = '0;
      res_d.click_sides  = clk_bits;
    end else begin
      res_d.side_value_0 = shown[0];
      res_d.side_value_1 = shown[1];
      res_d.side_value_2 = shown[2];
      res_d.side_value_3 = shown[3];
      res_d.side_value_4 = shown[4];
      res_d.side_value_5 = shown[5];
      res_d.click_sides  = '0;
    end

    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = res_q;

endmodule

### src/pulse_period_neighbor_decoder_core.sv
// Neighbour decoder for six pulse-period optical receivers. Each request carries a
// millisecond tick, a sample of the receiver pins or a query. A pin sample is first
// accepted; then every side lane checks its rising edge against the newest stored edge
// time, either counting a rapid pulse or pushing the time into its four-entry edge ring;
// a request is only produced when at least one side reaches its second rapid pulse. A
// query is first accepted; then each lane runs its single 32-bit subtractor over the age
// of the newest edge and then the three periods of its ring, after which the merging
// stage places every side's value at its output position. The last cycle of a pin
// sample or a query waits while the output register still holds a request that has not
// been taken. Configuration writes take effect at once and need no handshake; register
// 0 is the stale limit, 1 the period shift and 2 the rapid limit, with an unused index
// ignored.
module pulse_period_neighbor_decoder_core import ppnd_pkg::*; #(
  parameter int unsigned SIDES = SIDES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_req_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TIME_W-1:0] count_q, count_d;
  logic [PIN_W-1:0]  prev_q, prev_d;
  logic [PIN_W-1:0]  rise_q, rise_d;
  cfg_t              cfg_q, cfg_d;

  logic                        accept;
  logic                        out_free;
  logic                        last_step;
  lane_cmd_t                   cmd;
  logic [SIDES-1:0]            clicks;
  logic [SIDES-1:0][VAL_W-1:0] values;
  logic                        load;
  logic                        kind;

  assign accept    = in_valid_i && in_ready_o;
  // The output register can take a new request in this cycle.
  assign out_free  = !out_valid_o || out_ready_i;
  assign last_step = (step_q == STEP_W'(RING_DEPTH - 1));

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALE: cfg_d.stale_limit  = cfg_data_i;
        CFG_SHIFT: cfg_d.period_shift = cfg_data_i[2:0];
        CFG_RAPID: cfg_d.rapid_limit  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (accept) begin
          case (in_req_i.opcode)
            OP_PIN:   state_d = S_PIN;
            OP_QUERY: state_d = S_QRY;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_QRY: begin
        if (!last_step) begin
          step_d = step_q + STEP_W'(1);
        end else if (out_free) begin
          state_d = S_IDLE;
          step_d  = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // Sequencer outputs: handshake and lane commands.
  always_comb begin
    in_ready_o   = 1'b0;
    cmd.pin_en   = 1'b0;
    cmd.qry_en   = 1'b0;
    cmd.qry_last = 1'b0;
    cmd.step     = step_q;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_PIN:  cmd.pin_en = out_free;
      S_QRY: begin
        cmd.qry_en   = !last_step || out_free;
        cmd.qry_last = last_step && out_free;
      end
      default: begin
      end
    endcase
  end

  // Millisecond counter and pin edge detection, both updated on acceptance.
  always_comb begin
    count_d = count_q;
    prev_d  = prev_q;
    rise_d  = rise_q;
    if (accept) begin
      case (in_req_i.opcode)
        OP_TICK: count_d = count_q + TIME_W'(1);
        OP_PIN: begin
          rise_d = in_req_i.pin_levels & ~prev_q;
          prev_d = in_req_i.pin_levels;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      count_q <= '0;
      prev_q  <= '0;
      cfg_q   <= '{stale_limit: STALE_RST, period_shift: SHIFT_RST, rapid_limit: RAPID_RST};
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      prev_q  <= prev_d;
      cfg_q   <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rise_q <= rise_d;
  end

  // One lane per side; sides beyond the pin word never see an edge.
  for (genvar g = 0; g < SIDES; g++) begin : g_lane
    logic lane_rise;
    if (g < PIN_W) begin : g_pin
      assign lane_rise = rise_q[g];
    end else begin : g_nopin
      assign lane_rise = 1'b0;
    end

    ppnd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .rise_i  (lane_rise),
      .count_i (count_q),
      .cfg_i   (cfg_q),
      .click_o (clicks[g]),
      .value_o (values[g])
    );
  end

  // A click report is only produced when some side has just clicked; a query
  // always answers.
  assign load = (cmd.pin_en && (|clicks)) || cmd.qry_last;
  assign kind = (state_q == S_PIN);

  ppnd_merge #(
    .SIDES (SIDES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .kind_i      (kind),
    .clicks_i    (clicks),
    .values_i    (values),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

endmodule
